/* sv/wma_pkg.sv */
package wma_pkg;

  localparam int SAMPLE_W = 24;
  localparam int DIV_STEP_BITS = 4;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

/* sv/wma_sample_if.sv */
interface wma_sample_if;
  logic             valid;
  logic             ready;
  wma_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* sv/wma_average_if.sv */
interface wma_average_if;
  logic             valid;
  logic             ready;
  wma_pkg::sample_t average;

  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

/* sv/wma_ram.sv */
module wma_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* sv/warmup_moving_average_core.sv */
// Warm-up moving average of signed 24-bit samples. Each sample beat on the
// samples channel yields one beat on the means channel: the mean of the
// last min(n, WINDOW) samples since reset, truncated toward zero. Samples
// live in a WINDOW-entry ring memory; a running sum is updated by a
// read-modify-write of the ring slot. An accepted sample is registered;
// the load state writes it to the ring, updates the sum and loads the
// divider, which retires four quotient bits per cycle from the
// SUM_W-bit magnitude, SUM_W = 24 + clog2(WINDOW). The mean enters the
// output register once the division is done and the register is free.
// The next sample is taken once the result is registered, while it waits
// on the means channel. No clearing pass follows reset.
module warmup_moving_average_core #(
  parameter int WINDOW = 8
) (
  input  logic          clk,
  input  logic          rst,
  wma_sample_if.sink    samples,
  wma_average_if.source means
);

  localparam int SUM_W  = wma_pkg::SAMPLE_W + $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STEP   = wma_pkg::DIV_STEP_BITS;
  localparam int ITERS  = (SUM_W + STEP - 1) / STEP;
  localparam int QW     = ITERS * STEP;
  localparam int IT_W   = $clog2(ITERS + 1);

  wma_pkg::state_t state, state_next;

  logic                    in_ready;
  logic                    ram_we;
  logic                    div_run;
  logic                    out_load;

  wma_pkg::sample_t        sample_r;
  logic [wma_pkg::SAMPLE_W-1:0] ram_rdata;
  logic signed [SUM_W-1:0] running_sum;
  logic signed [SUM_W-1:0] running_sum_next;
  logic [CNT_W-1:0]        fill_count;
  logic [SLOT_W-1:0]       write_slot;
  logic                    ring_full;

  logic [CNT_W-1:0]        divisor;
  logic [QW-1:0]           dividend;
  logic [QW-1:0]           quotient;
  logic [CNT_W-1:0]        remainder;
  logic                    negative;
  logic [IT_W-1:0]         iter;

  logic [QW-1:0]           dividend_next;
  logic [QW-1:0]           quotient_next;
  logic [CNT_W-1:0]        remainder_next;

  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        mean;

  logic                    out_valid;
  wma_pkg::sample_t        average_r;

  wma_ram #(
    .WIDTH (wma_pkg::SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (write_slot),
    .wdata (sample_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      wma_pkg::ST_IDLE: begin
        if (samples.valid) begin
          state_next = wma_pkg::ST_LOAD;
        end
      end
      wma_pkg::ST_LOAD: begin
        state_next = wma_pkg::ST_DIV;
      end
      wma_pkg::ST_DIV: begin
        if (iter == IT_W'(ITERS - 1)) begin
          state_next = wma_pkg::ST_DONE;
        end
      end
      wma_pkg::ST_DONE: begin
        if (!out_valid || means.ready) begin
          state_next = wma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wma_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_we   = 1'b0;
    div_run  = 1'b0;
    out_load = 1'b0;
    case (state)
      wma_pkg::ST_IDLE: in_ready = 1'b1;
      wma_pkg::ST_LOAD: ram_we = 1'b1;
      wma_pkg::ST_DIV:  div_run = 1'b1;
      wma_pkg::ST_DONE: out_load = !out_valid || means.ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Drop the overwritten entry once the ring is full, then add the new sample.
  always_comb begin
    running_sum_next = running_sum + SUM_W'(sample_r);
    if (ring_full) begin
      running_sum_next = running_sum_next - SUM_W'($signed(ram_rdata));
    end
    sum_mag = running_sum_next[SUM_W-1] ? SUM_W'(-running_sum_next)
                                        : SUM_W'(running_sum_next);
  end

  always_ff @(posedge clk) begin
    if (in_ready && samples.valid) begin
      sample_r <= samples.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      fill_count  <= CNT_W'(1);
      write_slot  <= '0;
      ring_full   <= 1'b0;
    end else if (ram_we) begin
      running_sum <= running_sum_next;
      if (fill_count < CNT_W'(WINDOW)) begin
        fill_count <= fill_count + CNT_W'(1);
      end
      if (write_slot == SLOT_W'(WINDOW - 1)) begin
        write_slot <= '0;
        ring_full  <= 1'b1;
      end else begin
        write_slot <= write_slot + SLOT_W'(1);
      end
    end
  end

  // Restoring division, STEP quotient bits per cycle, most significant first.
  always_comb begin
    logic [CNT_W:0] trial;
    logic [QW-1:0]  dvd;
    logic [QW-1:0]  quo;
    logic [CNT_W-1:0] rem;
    dvd = dividend;
    quo = quotient;
    rem = remainder;
    for (int i = 0; i < STEP; i++) begin
      trial = {rem, dvd[QW-1]};
      dvd   = {dvd[QW-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
        quo   = {quo[QW-2:0], 1'b1};
      end else begin
        quo   = {quo[QW-2:0], 1'b0};
      end
      rem = trial[CNT_W-1:0];
    end
    dividend_next  = dvd;
    quotient_next  = quo;
    remainder_next = rem;
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      dividend  <= QW'(sum_mag);
      quotient  <= '0;
      remainder <= '0;
      divisor   <= fill_count;
      negative  <= running_sum_next[SUM_W-1];
      iter      <= '0;
    end else if (div_run) begin
      dividend  <= dividend_next;
      quotient  <= quotient_next;
      remainder <= remainder_next;
      iter      <= iter + IT_W'(1);
    end
  end

  assign mean = negative ? SUM_W'(-quotient[SUM_W-1:0]) : quotient[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (means.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_r <= mean[wma_pkg::SAMPLE_W-1:0];
    end
  end

  assign samples.ready = in_ready && !rst;
  assign means.valid   = out_valid;
  assign means.average = average_r;

endmodule
